>>> rtl/core/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg - shared types for the LRU byte-budget cache policy core
// Operation and result codes, sequencer states, and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lbc_pkg;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_TOUCH = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_EVICT = 2'd0,
		KIND_ALLOC = 2'd1,
		KIND_ERROR = 2'd2,
		KIND_DONE  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_CHECK,
		ST_A_READ,
		ST_A_EVICT,
		ST_A_ERROR,
		ST_A_LINK,
		ST_A_ALLOC,
		ST_T_READ,
		ST_T_UNLINK,
		ST_T_APPEND,
		ST_T_FINISH,
		ST_DONE,
		ST_CLEAR
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_ACCEPT,
		CMD_EVICT,
		CMD_ERROR,
		CMD_LINK,
		CMD_ALLOC,
		CMD_UNLINK,
		CMD_APPEND,
		CMD_FINISH,
		CMD_DONE,
		CMD_CLEAR
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   rd_idx;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic need_evict;
		logic protect;
		logic touch_skip;
	} status_t;

	localparam int SIZE_W  = 32;
	localparam int EPOCH_W = 16;
	localparam int IDX_W   = 4;

endpackage

>>> rtl/core/lbc_ctrl.sv
// ----------------------------------------------------------------------------
// lbc_ctrl - sequencer for the LRU byte-budget cache policy core
// Steps each word through allocate, touch, clear or no-op and issues at most one
// datapath command per cycle. Result-producing commands wait for the
// output register to be free.
// ----------------------------------------------------------------------------
module lbc_ctrl
	import lbc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  op_t       in_op,
	output logic      in_ready,
	input  status_t   status,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		in_ready   = 1'b0;
		cmd.op     = CMD_NONE;
		cmd.rd_idx = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = CMD_ACCEPT;
					unique case (in_op)
						OP_ALLOC: state_nxt = ST_A_CHECK;
						OP_TOUCH: state_nxt = ST_T_READ;
						OP_CLEAR: state_nxt = ST_CLEAR;
						OP_NOP:   state_nxt = ST_DONE;
					endcase
				end
			end
			ST_A_CHECK: begin
				priority if (!status.need_evict) begin
					state_nxt = ST_A_LINK;
				end else if (status.protect) begin
					state_nxt = ST_A_ERROR;
				end else begin
					state_nxt = ST_A_EVICT;
				end
			end
			ST_A_EVICT: begin
				if (status.out_free) begin
					cmd.op    = CMD_EVICT;
					state_nxt = ST_A_READ;
				end
			end
			// re-read the new head before checking again
			ST_A_READ: state_nxt = ST_A_CHECK;
			ST_A_ERROR: begin
				if (status.out_free) begin
					cmd.op    = CMD_ERROR;
					state_nxt = ST_IDLE;
				end
			end
			ST_A_LINK: begin
				cmd.op    = CMD_LINK;
				state_nxt = ST_A_ALLOC;
			end
			ST_A_ALLOC: begin
				if (status.out_free) begin
					cmd.op    = CMD_ALLOC;
					state_nxt = ST_IDLE;
				end
			end
			ST_T_READ: begin
				cmd.rd_idx = 1'b1;
				state_nxt  = ST_T_UNLINK;
			end
			ST_T_UNLINK: begin
				if (status.touch_skip) begin
					state_nxt = ST_DONE;
				end else begin
					cmd.op    = CMD_UNLINK;
					state_nxt = ST_T_APPEND;
				end
			end
			ST_T_APPEND: begin
				cmd.op    = CMD_APPEND;
				state_nxt = ST_T_FINISH;
			end
			ST_T_FINISH: begin
				if (status.out_free) begin
					cmd.op    = CMD_FINISH;
					state_nxt = ST_IDLE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.op    = CMD_DONE;
					state_nxt = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				if (status.out_free) begin
					cmd.op    = CMD_CLEAR;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

>>> rtl/core/lbc_dpath.sv
// ----------------------------------------------------------------------------
// lbc_dpath - datapath for the LRU byte-budget cache policy core
// Holds the entry memories, valid bits, list pointers, byte total,
// free-slot finder and the result output register.
// ----------------------------------------------------------------------------
module lbc_dpath
	import lbc_pkg::*;
#(
	parameter int ENTRIES = 16
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            status,
	input  logic [SIZE_W-1:0]  in_size,
	input  logic [IDX_W-1:0]   in_idx,
	input  logic [EPOCH_W-1:0] in_epoch,
	input  logic [31:0]        budget_limit,
	output logic               out_valid,
	input  logic               out_ready,
	output kind_t              out_kind,
	output logic [IDX_W-1:0]   out_entry,
	output logic [SIZE_W-1:0]  out_bytes,
	output logic               out_last
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// entry stores
	logic [SIZE_W-1:0]  bytes_mem [ENTRIES];
	logic [EPOCH_W-1:0] epoch_mem [ENTRIES];
	logic [IW-1:0]      next_mem  [ENTRIES];
	logic [IW-1:0]      prev_mem  [ENTRIES];

	logic [ENTRIES-1:0] valid_q;
	logic [IW-1:0]      head_q;
	logic [IW-1:0]      tail_q;
	logic               empty_q;
	logic [SIZE_W-1:0]  bytes_q;
	logic [IW-1:0]      free_idx_q;
	logic               any_free_q;

	logic [SIZE_W-1:0]  size_q;
	logic [IDX_W-1:0]   idx_q;
	logic [EPOCH_W-1:0] epoch_q;

	logic [SIZE_W-1:0]  bytes_rd_q;
	logic [EPOCH_W-1:0] epoch_rd_q;
	logic [IW-1:0]      next_rd_q;
	logic [IW-1:0]      prev_rd_q;

	logic [IW+IDX_W-1:0] idx_ext;
	logic [IW-1:0]       idx_iw;
	logic                idx_in_range;
	logic [IW-1:0]       next_addr;
	logic [SIZE_W:0]     sum_w;
	logic [SIZE_W-1:0]   bytes_add;
	logic [SIZE_W-1:0]   bytes_sub;
	logic [SIZE_W-1:0]   bytes_nxt;
	logic [IW:0]         free_scan;

	logic                nx_we;
	logic [IW-1:0]       nx_addr;
	logic [IW-1:0]       nx_data;
	logic                pv_we;
	logic [IW-1:0]       pv_addr;
	logic [IW-1:0]       pv_data;

	logic                emit;
	logic [IW+IDX_W-1:0] ent_ext;
	logic [IW-1:0]       ent_iw;
	kind_t               kind_nxt;

	function automatic logic [IW:0] first_free(input logic [ENTRIES-1:0] v);
		logic [IW:0] r;
		r = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!v[i]) begin
				r = {1'b1, IW'(i)};
			end
		end
		return r;
	endfunction

	assign idx_ext      = {{IW{1'b0}}, idx_q};
	assign idx_iw       = idx_ext[IW-1:0];
	assign idx_in_range = idx_ext < (IW + IDX_W)'(ENTRIES);
	assign next_addr    = cmd.rd_idx ? idx_iw : head_q;

	assign sum_w     = {1'b0, bytes_q} + {1'b0, size_q};
	assign bytes_add = sum_w[SIZE_W] ? '1 : sum_w[SIZE_W-1:0];
	assign bytes_sub = (bytes_q >= bytes_rd_q) ? bytes_q - bytes_rd_q : '0;
	assign free_scan = first_free(valid_q);

	assign status.out_free   = !out_valid || out_ready;
	assign status.need_evict = ((budget_limit != '0) && (sum_w > {1'b0, budget_limit}))
		|| !any_free_q;
	assign status.protect    = empty_q || (epoch_rd_q >= epoch_q);
	assign status.touch_skip = !idx_in_range || !valid_q[idx_iw] || empty_q
		|| (idx_iw == tail_q);

	// registered reads
	always_ff @(posedge clk) begin
		bytes_rd_q <= bytes_mem[head_q];
		epoch_rd_q <= epoch_mem[head_q];
		next_rd_q  <= next_mem[next_addr];
		prev_rd_q  <= prev_mem[idx_iw];
	end

	// link write ports
	always_comb begin
		nx_we   = 1'b0;
		nx_addr = tail_q;
		nx_data = '0;
		pv_we   = 1'b0;
		pv_addr = next_rd_q;
		pv_data = '0;
		unique case (cmd.op)
			CMD_LINK: begin
				nx_we   = !empty_q;
				nx_data = free_idx_q;
			end
			CMD_ALLOC: begin
				nx_we   = 1'b1;
				nx_addr = free_idx_q;
				pv_we   = 1'b1;
				pv_addr = free_idx_q;
				pv_data = empty_q ? '0 : tail_q;
			end
			CMD_EVICT: pv_we = (head_q != tail_q);
			CMD_UNLINK: begin
				pv_we = 1'b1;
				if (head_q != idx_iw) begin
					nx_we   = 1'b1;
					nx_addr = prev_rd_q;
					nx_data = next_rd_q;
					pv_data = prev_rd_q;
				end
			end
			CMD_APPEND: begin
				nx_we   = 1'b1;
				nx_data = idx_iw;
				pv_we   = 1'b1;
				pv_addr = idx_iw;
				pv_data = tail_q;
			end
			CMD_FINISH: begin
				nx_we   = 1'b1;
				nx_addr = idx_iw;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_addr] <= nx_data;
		end
		if (pv_we) begin
			prev_mem[pv_addr] <= pv_data;
		end
		if (cmd.op == CMD_ALLOC) begin
			bytes_mem[free_idx_q] <= size_q;
			epoch_mem[free_idx_q] <= epoch_q;
		end
	end

	// hold the item's fields
	always_ff @(posedge clk) begin
		if (cmd.op == CMD_ACCEPT) begin
			size_q  <= in_size;
			idx_q   <= in_idx;
			epoch_q <= in_epoch;
		end
	end

	always_comb begin
		unique case (cmd.op)
			CMD_EVICT: bytes_nxt = bytes_sub;
			CMD_ALLOC: bytes_nxt = bytes_add;
			CMD_CLEAR: bytes_nxt = '0;
			default:   bytes_nxt = bytes_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			empty_q    <= 1'b1;
			bytes_q    <= '0;
			free_idx_q <= '0;
			any_free_q <= 1'b1;
		end else begin
			bytes_q    <= bytes_nxt;
			free_idx_q <= free_scan[IW-1:0];
			any_free_q <= free_scan[IW];
			unique case (cmd.op)
				CMD_EVICT: begin
					valid_q[head_q] <= 1'b0;
					if (head_q == tail_q) begin
						empty_q <= 1'b1;
						head_q  <= '0;
						tail_q  <= '0;
					end else begin
						head_q <= next_rd_q;
					end
				end
				CMD_ALLOC: begin
					valid_q[free_idx_q] <= 1'b1;
					tail_q              <= free_idx_q;
					if (empty_q) begin
						head_q  <= free_idx_q;
						empty_q <= 1'b0;
					end
				end
				CMD_UNLINK: begin
					if (head_q == idx_iw) begin
						head_q <= next_rd_q;
					end
				end
				CMD_FINISH: tail_q <= idx_iw;
				CMD_CLEAR: begin
					valid_q <= '0;
					head_q  <= '0;
					tail_q  <= '0;
					empty_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_comb begin
		emit     = 1'b0;
		kind_nxt = KIND_DONE;
		ent_iw   = '0;
		unique case (cmd.op)
			CMD_EVICT: begin
				emit     = 1'b1;
				kind_nxt = KIND_EVICT;
				ent_iw   = head_q;
			end
			CMD_ALLOC: begin
				emit     = 1'b1;
				kind_nxt = KIND_ALLOC;
				ent_iw   = free_idx_q;
			end
			CMD_ERROR: begin
				emit     = 1'b1;
				kind_nxt = KIND_ERROR;
			end
			CMD_FINISH, CMD_DONE, CMD_CLEAR: emit = 1'b1;
			default: begin
			end
		endcase
	end

	assign ent_ext = {{IDX_W{1'b0}}, ent_iw};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind  <= kind_nxt;
			out_entry <= ent_ext[IDX_W-1:0];
			out_bytes <= bytes_nxt;
			out_last  <= (cmd.op != CMD_EVICT);
		end
	end

endmodule

>>> rtl/core/lru_budget_cache_policy_core.sv
// ----------------------------------------------------------------------------
// lru_budget_cache_policy_core - LRU replacement under a byte budget
// Keeps cached entries in least-recently-used order, evicts from the head
// to make room for an allocate word, moves touched entries to the tail.
//
//   channel  | dir | handshake                      | payload
//   ---------+-----+--------------------------------+-------------------------
//   s_*      | in  | s_tvalid / s_tready            | tuser op, tdata fields
//   m_*      | out | m_tvalid / m_tready            | tuser kind, tdata, tlast
//   apb      | in  | psel, penable, pwrite, pready  | budget_limit at 0x0
//
// Allocate evicts from the head (evict, re-read head, re-check) until the request
// fits and a slot is free, or ends in a budget error if the head epoch is not older
// than the request's; touch skips an out-of-range, invalid or tail entry, or an empty list.
// One list step per cycle unless a result stalls; one registered read port per memory sets it.
// Reset clears valid bits and pointers at once; no clearing pass runs.
// A result waits in the output register while m_tready is low; hold the sequencer until it frees.
// ----------------------------------------------------------------------------
module lru_budget_cache_policy_core
	import lbc_pkg::*;
#(
	parameter int ENTRIES = 16
)
(
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // request_size[31:0], entry_index[35:32],
	                              // current_epoch[51:36], zero pad[55:52]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // result_entry[3:0], bytes_in_use[35:4],
	                              // zero pad[39:36]
	output logic [1:0]  m_tuser,  // result_kind[1:0]
	output logic        m_tlast,  // last_result
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0]        budget_q;
	cmd_t               cmd;
	status_t            status;
	kind_t              out_kind;
	logic [IDX_W-1:0]   out_entry;
	logic [SIZE_W-1:0]  out_bytes;
	logic               cfg_hit;

	// single budget register; address 0x4 and up reads zero, ignores writes
	assign pready  = 1'b1;
	assign cfg_hit = (paddr[2] == 1'b0);
	assign prdata  = cfg_hit ? budget_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= '0;
		end else if (psel && penable && pwrite && pready && cfg_hit) begin
			budget_q <= pwdata;
		end
	end

	lbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (op_t'(s_tuser)),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lbc_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.in_size      (s_tdata[31:0]),
		.in_idx       (s_tdata[35:32]),
		.in_epoch     (s_tdata[51:36]),
		.budget_limit (budget_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_kind     (out_kind),
		.out_entry    (out_entry),
		.out_bytes    (out_bytes),
		.out_last     (m_tlast)
	);

	// pack the result word
	assign m_tuser = out_kind;
	assign m_tdata = {4'b0000, out_bytes, out_entry};

endmodule

>>> test/lru_budget_cache_policy_core_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_budget_cache_policy_core_chk - result checker for the LRU budget core
// Tracks budget writes and accepted request words, keeps its own copy of the
// LRU list and byte total, and compares each result word, field by field,
// with the oldest outcome still owed.
// ----------------------------------------------------------------------------
module lru_budget_cache_policy_core_chk
	import lbc_pkg::*;
#(
	parameter logic [2:0] BUDGET_ADDR = 3'd0,
	parameter int         ENTRIES     = 16
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,  // request_size, entry_index, current_epoch, pad
	input  logic [1:0]  s_tuser,  // operation
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,  // result_entry, bytes_in_use, pad
	input  logic [1:0]  m_tuser,  // result_kind
	input  logic        m_tlast,  // last_result
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  entry;
		logic [31:0] bytes;
		logic        last;
	} cache_result_t;

	cache_result_t outcome_q[$];

	logic [31:0] budget;
	logic        live  [ENTRIES];
	logic [31:0] nbytes[ENTRIES];
	logic [15:0] born  [ENTRIES];
	logic [3:0]  fwd   [ENTRIES];
	logic [3:0]  back  [ENTRIES];
	logic [3:0]  lru_head;
	logic [3:0]  mru_tail;
	logic        table_empty;
	logic [31:0] total_bytes;
	int          miss_count;

	assign fail_count = miss_count;

	function automatic int first_free();
		for (int i = 0; i < ENTRIES; i++)
			if (!live[i])
				return i;
		return -1;
	endfunction

	function automatic bit exceeds(logic [31:0] size);
		return (budget != 32'd0) &&
		       ({1'b0, total_bytes} + {1'b0, size} > {1'b0, budget});
	endfunction

	task automatic owe(kind_t kind, logic [3:0] entry, bit last);
		cache_result_t r;
		r.kind  = kind;
		r.entry = entry;
		r.bytes = total_bytes;
		r.last  = last;
		outcome_q.push_back(r);
	endtask

	task automatic link_at_tail(logic [3:0] idx);
		fwd[idx] = 4'd0;
		if (table_empty) begin
			back[idx]   = 4'd0;
			lru_head    = idx;
			table_empty = 1'b0;
		end else begin
			back[idx]     = mru_tail;
			fwd[mru_tail] = idx;
		end
		mru_tail = idx;
	endtask

	// evict from the head until the request fits and a slot is free
	task automatic lru_allocate(logic [31:0] size, logic [15:0] ep);
		logic [3:0]  victim;
		logic [32:0] sum;
		int          slot;
		while (exceeds(size) || first_free() < 0) begin
			if (table_empty || born[lru_head] >= ep) begin
				owe(KIND_ERROR, 4'd0, 1'b1);
				return;
			end
			victim = lru_head;
			if (victim == mru_tail) begin
				table_empty = 1'b1;
				lru_head    = 4'd0;
				mru_tail    = 4'd0;
			end else begin
				lru_head       = fwd[victim];
				back[lru_head] = 4'd0;
			end
			live[victim] = 1'b0;
			total_bytes  = (total_bytes >= nbytes[victim]) ?
			               total_bytes - nbytes[victim] : 32'd0;
			owe(KIND_EVICT, victim, 1'b0);
		end
		slot        = first_free();
		sum         = {1'b0, total_bytes} + {1'b0, size};
		total_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		live[slot]   = 1'b1;
		nbytes[slot] = size;
		born[slot]   = ep;
		link_at_tail(slot[3:0]);
		owe(KIND_ALLOC, slot[3:0], 1'b1);
	endtask

	task automatic lru_touch(logic [3:0] idx);
		if (live[idx] && !table_empty && idx != mru_tail) begin
			if (idx == lru_head) begin
				lru_head       = fwd[idx];
				back[lru_head] = 4'd0;
			end else begin
				fwd[back[idx]] = fwd[idx];
				back[fwd[idx]] = back[idx];
			end
			link_at_tail(idx);
		end
		owe(KIND_DONE, 4'd0, 1'b1);
	endtask

	task automatic lru_clear();
		for (int i = 0; i < ENTRIES; i++)
			live[i] = 1'b0;
		lru_head    = 4'd0;
		mru_tail    = 4'd0;
		table_empty = 1'b1;
		total_bytes = 32'd0;
	endtask

	task automatic report_miss(string what, cache_result_t want, cache_result_t got);
		if (miss_count < 10)
			$display("%0t lru check: %s: want k%0d e%0d b%h l%b, got k%0d e%0d b%h l%b",
			         $time, what, want.kind, want.entry, want.bytes, want.last,
			         got.kind, got.entry, got.bytes, got.last);
		miss_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cache_result_t got;
		cache_result_t want;
		if (!arst_n) begin
			budget = 32'd0;
			for (int i = 0; i < ENTRIES; i++) begin
				live[i]   = 1'b0;
				nbytes[i] = 32'd0;
				born[i]   = 16'd0;
				fwd[i]    = 4'd0;
				back[i]   = 4'd0;
			end
			lru_clear();
			outcome_q.delete();
			miss_count = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == BUDGET_ADDR)
				budget = pwdata;
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					OP_ALLOC: lru_allocate(s_tdata[31:0], s_tdata[51:36]);
					OP_TOUCH: lru_touch(s_tdata[35:32]);
					OP_CLEAR: begin
						lru_clear();
						owe(KIND_DONE, 4'd0, 1'b1);
					end
					default:  owe(KIND_DONE, 4'd0, 1'b1);
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.kind  = kind_t'(m_tuser);
				got.entry = m_tdata[3:0];
				got.bytes = m_tdata[35:4];
				got.last  = m_tlast;
				if (outcome_q.size() == 0) begin
					report_miss("result with nothing owed", '0, got);
				end else begin
					want = outcome_q.pop_front();
					if (got.kind != want.kind || got.entry != want.entry ||
					    got.bytes != want.bytes || got.last != want.last)
						report_miss("result mismatch", want, got);
				end
			end
			pending <= outcome_q.size();
		end
	end

endmodule

>>> test/lru_budget_cache_policy_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_budget_cache_policy_core_tb - stimulus for the LRU byte-budget core
// Drives directed words, then random bursts, against a receiver that stalls
// on its own pattern, rewrites the byte budget between phases while the core
// is idle, and leaves all result checking to the checker beside the core.
// ----------------------------------------------------------------------------
module lru_budget_cache_policy_core_tb;
	import lbc_pkg::*;

	localparam logic [2:0] BUDGET_ADDR  = 3'd0;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         CHOKE_CYCLES = 300;
	localparam int         SETTLE       = 40;
	localparam int         PHASE_WORDS  = 21;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata  = '0;  // request_size[31:0], entry_index[35:32],
	                             // current_epoch[51:36], zero pad[55:52]
	logic [1:0]  s_tuser  = '0;  // operation[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // result_entry[3:0], bytes_in_use[35:4],
	                             // zero pad[39:36]
	logic [1:0]  m_tuser;        // result_kind[1:0]
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	int          fail_count;
	int          pending;
	int          cycles      = 0;
	bit          choke_go    = 1'b0;
	bit          choke_seen  = 1'b0;
	int          burst_left  = 0;
	logic [15:0] epoch_now   = 16'd100;
	logic [31:0] size_cap    = 32'd4000;

	lru_budget_cache_policy_core #(.ENTRIES(16)) dut (.*);

	lru_budget_cache_policy_core_chk #(.BUDGET_ADDR(BUDGET_ADDR)) chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the core hangs or a result never shows up.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("lru_budget_cache_policy_core_tb: done, errors");
			$finish;
		end
	end

	// Receiver: cycle through stall patterns picked by cycles[8:7], from always
	// ready to one-in-three. Once the stimulus asks, hold off for a long
	// stretch so the core backs up and drops s_tready.
	initial begin
		forever begin
			@(posedge clk);
			if (choke_go && !choke_seen) begin
				choke_seen = 1'b1;
				m_tready <= 1'b0;
				repeat (CHOKE_CYCLES) @(posedge clk);
			end else begin
				case (cycles[8:7])
					2'd0: m_tready <= 1'b1;
					2'd1: m_tready <= 1'($urandom_range(0, 1));
					2'd2: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= ($urandom_range(0, 2) == 0);
				endcase
			end
		end
	end

	// Offer one request word and hold it until accepted; then maybe open a
	// gap before the next burst. Valid stays high across a burst.
	task automatic offer_word(op_t op, logic [31:0] size, logic [3:0] idx,
	                          logic [15:0] ep);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, ep, idx, size};
		do @(posedge clk); while (!s_tready);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// Stop offering and wait until every owed result has come back, then
	// let the core settle.
	task automatic drain_results(int settle);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (settle) @(posedge clk);
	endtask

	// Budget writes go in only while the core is idle.
	task automatic set_budget(logic [31:0] limit);
		drain_results(SETTLE);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= BUDGET_ADDR;
		pwdata  <= limit;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mostly allocates with rising epochs so the head stays evictable;
	// now and then an old or wild epoch to hit the protected head.
	task automatic random_word();
		int          pick;
		int          roll;
		logic [31:0] size;
		logic [15:0] ep;
		roll = $urandom_range(0, 31);
		if (roll == 0)
			size = 32'hFFFF_FFFF;
		else if (roll == 1)
			size = $urandom;
		else if (roll == 2)
			size = 32'd0;
		else
			size = $urandom_range(0, size_cap);
		roll = $urandom_range(0, 15);
		if (roll == 0)
			ep = 16'($urandom_range(0, 65535));
		else if (roll == 1)
			ep = 16'($urandom_range(0, epoch_now));
		else if (roll == 2)
			ep = epoch_now;
		else begin
			epoch_now = epoch_now + 16'd1;
			ep = epoch_now;
		end
		pick = $urandom_range(0, 99);
		if (pick < 62)
			offer_word(OP_ALLOC, size, 4'($urandom_range(0, 15)), ep);
		else if (pick < 94)
			offer_word(OP_TOUCH, size, 4'($urandom_range(0, 15)), ep);
		else if (pick < 97)
			offer_word(OP_CLEAR, size, 4'($urandom_range(0, 15)), ep);
		else
			offer_word(OP_NOP, size, 4'($urandom_range(0, 15)), ep);
	endtask

	initial begin
		logic [31:0] limits[4];
		logic [31:0] caps[4];
		limits = '{32'd0, 32'd1000, 32'hFFFF_FFFF, 32'd1};
		caps   = '{32'd4000, 32'd300, 32'hFFFF_FFFF, 32'd1};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, unlimited budget.
		set_budget(32'd0);
		offer_word(OP_NOP, 32'd0, 4'd0, 16'd0);
		// touch on an empty table: ignored
		offer_word(OP_TOUCH, 32'd0, 4'd5, 16'd0);
		offer_word(OP_ALLOC, 32'hFFFF_FFFF, 4'd0, 16'd1);
		// total saturates
		offer_word(OP_ALLOC, 32'h0000_0010, 4'd0, 16'd2);
		// touch the head, then touch the tail
		offer_word(OP_TOUCH, 32'd0, 4'd0, 16'd0);
		offer_word(OP_TOUCH, 32'd0, 4'd0, 16'd0);
		offer_word(OP_ALLOC, 32'd0, 4'd0, 16'hFFFF);
		// fill the table up to every slot
		for (int i = 3; i < 16; i++)
			offer_word(OP_ALLOC, (i % 2 == 0) ? 32'h5555_5555 : 32'hAAAA_AAAA,
			           4'd0, 16'(i + 7));
		// full table with a head that is too young: budget error
		offer_word(OP_ALLOC, 32'd1, 4'd0, 16'd0);
		// full table: evict the head, then allocate
		offer_word(OP_ALLOC, 32'hAAAA_AAAA, 4'd0, 16'd5);
		// move a middle entry to the tail
		offer_word(OP_TOUCH, 32'd0, 4'd2, 16'd0);
		offer_word(OP_ALLOC, 32'd7, 4'd15, 16'h8000);
		offer_word(OP_CLEAR, 32'd0, 4'd0, 16'd0);

		// Random phases, one budget each.
		for (int p = 0; p < 4; p++) begin
			set_budget(limits[p]);
			size_cap = caps[p];
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (p == 1 && n == 6)
					choke_go <= 1'b1;
				if (p == 2 && n == 14)
					drain_results(0);
				random_word();
			end
		end

		drain_results(SETTLE);
		if (fail_count == 0)
			$display("lru_budget_cache_policy_core_tb: done, clean");
		else
			$display("lru_budget_cache_policy_core_tb: done, errors");
		$finish;
	end

endmodule
